// File: hw/rtl/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg
// shared types and constants of the 3x3 rgb line filter
// ----------------------------------------------------------------------------
package lef_pkg;

    localparam int CH_W       = 16;
    localparam int NUM_CH     = 3;
    localparam int PX_W       = CH_W * NUM_CH;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SIDE_CFG_W = 11;

    // output queue, one entry per pixel that yields results
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = 3;
    localparam int OQ_CNT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_MAX_VALUE    = 2'd2
    } lef_cfg_idx_t;

    // everything one pixel contributes to the output stream
    typedef struct packed {
        logic                              has_inner;
        logic                              has_border;
        logic [POS_W-1:0]                  row;
        logic [POS_W-1:0]                  col;
        logic [NUM_CH-1:0][CH_W-1:0]       vert;
        logic [NUM_CH-1:0][CH_W-1:0]       horiz;
        logic [NUM_CH-1:0][CH_W-1:0]       pix;
    } lef_entry_t;

    // one result as seen on the output port
    typedef struct packed {
        logic [POS_W-1:0]                  row;
        logic [POS_W-1:0]                  col;
        logic [NUM_CH-1:0][CH_W-1:0]       vert;
        logic [NUM_CH-1:0][CH_W-1:0]       horiz;
        logic                              last;
    } lef_result_t;

endpackage

// File: hw/rtl/lef_ram.sv
// ----------------------------------------------------------------------------
// lef_ram
// simple dual-port ram, registered read, read returns old data on collision
// ----------------------------------------------------------------------------
module lef_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/lef_out_queue.sv
// ----------------------------------------------------------------------------
// lef_out_queue
// per-pixel result queue, unpacks each entry into one or two transfers
// ----------------------------------------------------------------------------
module lef_out_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  lef_pkg::lef_entry_t          push_entry,
    output logic [lef_pkg::OQ_CNT_W-1:0] count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output lef_pkg::lef_result_t         result
);
    import lef_pkg::*;

    lef_entry_t            entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic                  half_reg, half_next;
    lef_entry_t            head;
    logic                  show_inner;
    logic                  xfer;
    logic                  pop;

    assign head       = entry_reg[rd_ptr_reg];
    assign out_valid  = (count_reg != '0);
    assign show_inner = head.has_inner && !half_reg;
    assign xfer       = out_valid && !out_stall;
    // an entry with both results stays for a second transfer
    assign pop        = xfer && !(show_inner && head.has_border);
    assign count      = count_reg;

    always_comb
    begin
        result.row   = show_inner ? head.row - 1'b1 : head.row;
        result.col   = show_inner ? head.col - 1'b1 : head.col;
        result.vert  = show_inner ? head.vert : head.pix;
        result.horiz = show_inner ? head.horiz : head.pix;
        result.last  = show_inner ? !head.has_border : 1'b1;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
        half_next   = half_reg;
        if (xfer)
        begin
            half_next = !pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            half_reg   <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != OQ_CNT_W'(OQ_DEPTH)))
        else $error("push into full output queue");

    a_half_both: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (out_valid && head.has_inner && head.has_border))
        else $error("second half pending on entry without two results");

endmodule

// File: hw/rtl/line_edge_filter_3x3_rgb_top.sv
// ----------------------------------------------------------------------------
// line_edge_filter_3x3_rgb_top
// 3x3 vertical and horizontal line detection on an rgb raster stream
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall, red_in, green_in, blue_in): one rgb
//   pixel per transfer in raster order. output channel (out_valid /
//   out_stall): one result per transfer with pixel_row/pixel_col, the
//   clamped vertical and horizontal filter values per channel and
//   last_of_run on the final result caused by one input pixel. interior
//   pixel (r-1,c-1) is reported when pixel (r,c) arrives, before the border
//   result of that same pixel; border pixels pass their samples through.
//   config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0
//   frame_width, 1 frame_height, 2 max_value; cfg_ready is always high and
//   writes are meant for idle periods only.
// timing
//   a pixel passes stage 1, stage 2 and the output queue before its first
//   result transfer. one pixel per clock while in_stall is low; a pixel with
//   two results (last row or last column from index 2 on) takes two output
//   transfers, so the 8-entry queue takes up short bursts and along the last
//   row input is throttled. line stores: single read, single write rams,
//   once per pixel, with same-column forwarding for a one-pixel-wide frame.
// reset and stall
//   reset clears counters and pipeline and loads 640x480, max 255. no clear
//   pass: line stores are written before they are read. when the receiver
//   stalls, the queue fills and in_stall rises once queue plus pipeline
//   could hold no further pixel.
// ----------------------------------------------------------------------------
module line_edge_filter_3x3_rgb_top #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lef_pkg::CH_W-1:0]       red_in,
    input  logic [lef_pkg::CH_W-1:0]       green_in,
    input  logic [lef_pkg::CH_W-1:0]       blue_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lef_pkg::POS_W-1:0]      pixel_row,
    output logic [lef_pkg::POS_W-1:0]      pixel_col,
    output logic [lef_pkg::CH_W-1:0]       vert_red,
    output logic [lef_pkg::CH_W-1:0]       vert_green,
    output logic [lef_pkg::CH_W-1:0]       vert_blue,
    output logic [lef_pkg::CH_W-1:0]       horiz_red,
    output logic [lef_pkg::CH_W-1:0]       horiz_green,
    output logic [lef_pkg::CH_W-1:0]       horiz_blue,
    output logic                           last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lef_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lef_pkg::*;

    // counter and store address width
    localparam int CW = $clog2(MAX_SIDE);
    localparam int SUM_W = CH_W + 2;
    localparam int WLAST_RST = (640 > MAX_SIDE) ? MAX_SIDE - 1 : 639;
    localparam int HLAST_RST = (480 > MAX_SIDE) ? MAX_SIDE - 1 : 479;

    // last index of a side, with out-of-range sizes folded into 1..MAX_SIDE
    function automatic logic [CW-1:0] side_last(input logic [SIDE_CFG_W-1:0] v);
        int iv;
        iv = int'(v);
        if (iv < 1)
        begin
            iv = 1;
        end
        if (iv > MAX_SIDE)
        begin
            iv = MAX_SIDE;
        end
        return CW'(iv - 1);
    endfunction

    // -a + 2b - c of three column or row sums, clamped to 0..maxv
    function automatic logic [CH_W-1:0] combine_clamp(
        input logic [SUM_W-1:0] lo,
        input logic [SUM_W-1:0] mid,
        input logic [SUM_W-1:0] hi,
        input logic [CH_W-1:0]  maxv
    );
        logic signed [SUM_W+2:0] s;
        logic [CH_W-1:0]         res;
        s = $signed({2'b00, mid, 1'b0}) - $signed({3'b000, lo})
            - $signed({3'b000, hi});
        if (s < 0)
        begin
            res = '0;
        end
        else if (s > $signed({3'b000, {(SUM_W-CH_W){1'b0}}, maxv}))
        begin
            res = maxv;
        end
        else
        begin
            res = s[CH_W-1:0];
        end
        return res;
    endfunction

    // configuration
    logic [CW-1:0]   wlast_reg;
    logic [CW-1:0]   hlast_reg;
    logic [CH_W-1:0] max_reg;

    // raster position of the next pixel
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;

    logic in_acc;
    logic inner0, border0;
    logic fwd_next;

    // stage 1: line store data is on the ram outputs
    logic              s1_valid_reg;
    logic              s1_fwd_reg;
    logic              s1_inner_reg;
    logic              s1_border_reg;
    logic [CW-1:0]     s1_row_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [PX_W-1:0]   s1_px_reg;
    logic [PX_W-1:0]   fwd_old_reg;
    logic [PX_W-1:0]   fwd_new_reg;
    logic [PX_W-1:0]   old_q, new_q;
    logic [PX_W-1:0]   cur [3];
    logic [PX_W-1:0]   win_reg [6];
    logic [SUM_W-1:0]  col_sum [NUM_CH][3];
    logic [SUM_W-1:0]  row_sum [NUM_CH][3];

    // stage 2: window sums registered
    logic              s2_valid_reg;
    logic              s2_inner_reg;
    logic              s2_border_reg;
    logic [CW-1:0]     s2_row_reg;
    logic [CW-1:0]     s2_col_reg;
    logic [PX_W-1:0]   s2_px_reg;
    logic [SUM_W-1:0]  s2_col_sum_reg [NUM_CH][3];
    logic [SUM_W-1:0]  s2_row_sum_reg [NUM_CH][3];

    logic                oq_push;
    lef_entry_t          oq_entry;
    logic [OQ_CNT_W-1:0] oq_count;
    lef_result_t         res;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= CW'(WLAST_RST);
            hlast_reg <= CW'(HLAST_RST);
            max_reg   <= CH_W'(255);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (lef_cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  wlast_reg <= side_last(cfg_data[SIDE_CFG_W-1:0]);
                CFG_FRAME_HEIGHT: hlast_reg <= side_last(cfg_data[SIDE_CFG_W-1:0]);
                CFG_MAX_VALUE:    max_reg   <= cfg_data[CH_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0: accept, classify, issue line store reads
    // ------------------------------------------------------------------
    // credit check: every pixel in flight may need a queue entry
    assign in_stall = (int'(oq_count) + int'(s1_valid_reg) + int'(s2_valid_reg))
                      >= OQ_DEPTH;
    assign in_acc   = in_valid && !in_stall;

    assign inner0  = (row_reg >= CW'(2)) && (col_reg >= CW'(2))
                     && (row_reg <= hlast_reg) && (col_reg <= wlast_reg);
    assign border0 = (row_reg == '0) || (col_reg == '0)
                     || (row_reg >= hlast_reg) || (col_reg >= wlast_reg);

    // same column read and written on one edge only for one-pixel-wide rows
    assign fwd_next = in_acc && s1_valid_reg && (s1_col_reg == col_reg);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (in_acc)
        begin
            if (col_reg >= wlast_reg)
            begin
                col_next = '0;
                row_next = (row_reg >= hlast_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= in_acc;
            s1_fwd_reg   <= fwd_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // line stores: older holds row r-2, newer holds row r-1
    // ------------------------------------------------------------------
    lef_ram #(
        .WIDTH (PX_W),
        .DEPTH (MAX_SIDE)
    ) u_older_store (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (cur[1]),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (old_q)
    );

    lef_ram #(
        .WIDTH (PX_W),
        .DEPTH (MAX_SIDE)
    ) u_newer_store (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_px_reg),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (new_q)
    );

    // ------------------------------------------------------------------
    // stage 1: column of the window, store write-back, partial sums
    // ------------------------------------------------------------------
    always_comb
    begin
        cur[0] = s1_fwd_reg ? fwd_old_reg : old_q;
        cur[1] = s1_fwd_reg ? fwd_new_reg : new_q;
        cur[2] = s1_px_reg;
    end

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            col_sum[ch][0] = SUM_W'(win_reg[0][CH_W*ch +: CH_W])
                           + SUM_W'(win_reg[2][CH_W*ch +: CH_W])
                           + SUM_W'(win_reg[4][CH_W*ch +: CH_W]);
            col_sum[ch][1] = SUM_W'(win_reg[1][CH_W*ch +: CH_W])
                           + SUM_W'(win_reg[3][CH_W*ch +: CH_W])
                           + SUM_W'(win_reg[5][CH_W*ch +: CH_W]);
            col_sum[ch][2] = SUM_W'(cur[0][CH_W*ch +: CH_W])
                           + SUM_W'(cur[1][CH_W*ch +: CH_W])
                           + SUM_W'(cur[2][CH_W*ch +: CH_W]);
            for (int k = 0; k < 3; k++)
            begin
                row_sum[ch][k] = SUM_W'(win_reg[2*k][CH_W*ch +: CH_W])
                               + SUM_W'(win_reg[2*k+1][CH_W*ch +: CH_W])
                               + SUM_W'(cur[k][CH_W*ch +: CH_W]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            s1_inner_reg  <= inner0;
            s1_border_reg <= border0;
            s1_px_reg     <= {blue_in, green_in, red_in};
        end
        if (fwd_next)
        begin
            fwd_old_reg <= cur[1];
            fwd_new_reg <= s1_px_reg;
        end
        if (s1_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[2*k]   <= win_reg[2*k+1];
                win_reg[2*k+1] <= cur[k];
            end
            s2_row_reg     <= s1_row_reg;
            s2_col_reg     <= s1_col_reg;
            s2_inner_reg   <= s1_inner_reg;
            s2_border_reg  <= s1_border_reg;
            s2_px_reg      <= s1_px_reg;
            s2_col_sum_reg <= col_sum;
            s2_row_sum_reg <= row_sum;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: kernel combine and clamp into the output queue
    // ------------------------------------------------------------------
    assign oq_push = s2_valid_reg && (s2_inner_reg || s2_border_reg);

    always_comb
    begin
        oq_entry.has_inner  = s2_inner_reg;
        oq_entry.has_border = s2_border_reg;
        oq_entry.row        = POS_W'(s2_row_reg);
        oq_entry.col        = POS_W'(s2_col_reg);
        oq_entry.pix        = s2_px_reg;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            oq_entry.vert[ch]  = combine_clamp(s2_col_sum_reg[ch][0],
                                               s2_col_sum_reg[ch][1],
                                               s2_col_sum_reg[ch][2], max_reg);
            oq_entry.horiz[ch] = combine_clamp(s2_row_sum_reg[ch][0],
                                               s2_row_sum_reg[ch][1],
                                               s2_row_sum_reg[ch][2], max_reg);
        end
    end

    lef_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (oq_push),
        .push_entry (oq_entry),
        .count      (oq_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (res)
    );

    assign pixel_row   = res.row;
    assign pixel_col   = res.col;
    assign vert_red    = res.vert[0];
    assign vert_green  = res.vert[1];
    assign vert_blue   = res.vert[2];
    assign horiz_red   = res.horiz[0];
    assign horiz_green = res.horiz[1];
    assign horiz_blue  = res.horiz[2];
    assign last_of_run = res.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted pixel missing from stage 1");

    a_fwd_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> (s1_valid_reg && $past(s1_valid_reg)))
        else $error("store forwarding without a preceding write");

    a_inner_position: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_inner_reg) |-> (s1_row_reg >= CW'(2) && s1_col_reg >= CW'(2)))
        else $error("interior result at a border position");

endmodule
